// ----- rtl/core/rc4_keystream_cipher_assert.svh -----
// assertion macros for the rc4 keystream cipher
`ifndef RC4_KEYSTREAM_CIPHER_ASSERT_SVH
`define RC4_KEYSTREAM_CIPHER_ASSERT_SVH

`ifndef SYNTH
`define RC4_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc4 assertion failed");
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMP(lbl, ante, cons)
`define RC4_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/rc4_pkg.sv -----
// types and constants shared by the rc4 keystream cipher
`default_nettype none

package rc4_pkg;

    localparam int BOX_DEPTH = 256;
    localparam int BOX_W     = 8;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOKEY = 1'b1;

    localparam logic [BOX_W-1:0] BOX_LAST = 8'hff;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_K_INIT = 10'b00_0000_0010,
        ST_K_RD   = 10'b00_0000_0100,
        ST_K_J    = 10'b00_0000_1000,
        ST_K_W1   = 10'b00_0001_0000,
        ST_K_W2   = 10'b00_0010_0000,
        ST_D_J    = 10'b00_0100_0000,
        ST_D_SW   = 10'b00_1000_0000,
        ST_D_KS   = 10'b01_0000_0000,
        ST_EMIT   = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rc4_keystream_cipher.sv -----
// rc4 engine: key store, state box in a synchronous memory, keystream xor
// key byte: stored. last key byte: schedule of identity writes to all 256 entries, then
// per entry a read, a dependent read and two writes through the single box write port.
// data byte: D_J, D_SW, D_KS (swap needs two box writes), then the output register, via
// EMIT while it is full; next byte taken only in idle. unkeyed data goes via EMIT.
// async active-low reset clears control, indices, key count and keyed flag; memories unset
`default_nettype none

module rc4_keystream_cipher #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  wire logic [0:0] s_axis_tuser,   // [0] req_type
    input  wire logic       s_axis_tlast,   // last_in

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] byte_out
    output logic [0:0]      m_axis_tuser,   // [0] status
    output logic            m_axis_tlast    // last_out
);

    `include "rc4_keystream_cipher_assert.svh"

    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEY_BYTES);

    // memories
    logic [rc4_pkg::BOX_W-1:0] box_mem [rc4_pkg::BOX_DEPTH];
    logic [7:0]                key_mem [MAX_KEY_BYTES];

    logic                      box_we;
    logic [7:0]                box_wa;
    logic [7:0]                box_wd;
    logic                      box_re;
    logic [7:0]                box_ra;
    logic [7:0]                box_rd_reg;

    logic                      key_we;
    logic [KIDX_W-1:0]         key_wa;
    logic                      key_re;
    logic [7:0]                key_rd_reg;

    // control
    rc4_pkg::state_t           state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          len_reg, len_next;
    logic                      keyed_reg, keyed_next;
    logic [7:0]                i_reg, i_next;
    logic [7:0]                j_reg, j_next;
    logic [KIDX_W-1:0]         pos_reg, pos_next;
    logic                      out_valid_reg, out_valid_next;

    // payload
    logic [7:0]                si_reg, si_next;
    logic [7:0]                sj_reg, sj_next;
    logic [7:0]                t_reg, t_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      last_reg, last_next;
    logic                      status_reg, status_next;
    logic [7:0]                out_byte_reg;
    logic                      out_status_reg;
    logic                      out_last_reg;

    logic                      s_beat;
    logic                      out_free;
    logic                      out_load;
    logic [7:0]                sum_j;
    logic [CNT_W-1:0]          pos_inc;
    logic [7:0]                ks_fwd;
    logic [7:0]                res_byte;

    assign s_axis_tready = (state_reg == rc4_pkg::ST_IDLE);
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_byte_reg;
    assign m_axis_tuser[0] = out_status_reg;
    assign m_axis_tlast    = out_last_reg;

    // j update shares one adder between the schedule and the stream
    assign sum_j = 8'(j_reg + box_rd_reg
                      + ((state_reg == rc4_pkg::ST_K_J) ? key_rd_reg : 8'd0));
    assign pos_inc = CNT_W'(pos_reg) + CNT_W'(1);

    // box[t] was read before the swap landed: take the swapped values, j write wins
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks_fwd = si_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks_fwd = sj_reg;
        end
        else
        begin
            ks_fwd = box_rd_reg;
        end
    end

    assign res_byte = (status_reg == rc4_pkg::STATUS_NOKEY) ? byte_reg : (byte_reg ^ ks_fwd);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        keyed_next  = keyed_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pos_next    = pos_reg;
        si_next     = si_reg;
        sj_next     = sj_reg;
        t_next      = t_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        status_next = status_reg;
        box_we      = 1'b0;
        box_wa      = i_reg;
        box_wd      = i_reg;
        box_re      = 1'b0;
        box_ra      = i_reg;
        key_we      = 1'b0;
        key_wa      = count_reg[KIDX_W-1:0];
        key_re      = 1'b0;
        out_load    = 1'b0;

        unique case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (s_beat)
                begin
                    byte_next = s_axis_tdata;
                    last_next = s_axis_tlast;
                    if (s_axis_tuser[0] == rc4_pkg::REQ_KEY)
                    begin
                        // bytes past the store size are dropped, count saturates
                        if (count_reg < MAX_CNT)
                        begin
                            key_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        if (s_axis_tlast)
                        begin
                            len_next   = count_next;
                            count_next = '0;
                            i_next     = '0;
                            j_next     = '0;
                            pos_next   = '0;
                            state_next = rc4_pkg::ST_K_INIT;
                        end
                    end
                    else if (keyed_reg)
                    begin
                        i_next      = 8'(i_reg + 8'd1);
                        box_re      = 1'b1;
                        box_ra      = i_next;
                        status_next = rc4_pkg::STATUS_OK;
                        state_next  = rc4_pkg::ST_D_J;
                    end
                    else
                    begin
                        status_next = rc4_pkg::STATUS_NOKEY;
                        state_next  = rc4_pkg::ST_EMIT;
                    end
                end
            end

            rc4_pkg::ST_K_INIT:
            begin
                box_we = 1'b1;
                i_next = 8'(i_reg + 8'd1);
                if (i_reg == rc4_pkg::BOX_LAST)
                begin
                    state_next = rc4_pkg::ST_K_RD;
                end
            end

            rc4_pkg::ST_K_RD:
            begin
                box_re     = 1'b1;
                key_re     = 1'b1;
                state_next = rc4_pkg::ST_K_J;
            end

            rc4_pkg::ST_K_J:
            begin
                si_next    = box_rd_reg;
                box_re     = 1'b1;
                box_ra     = sum_j;
                j_next     = sum_j;
                state_next = rc4_pkg::ST_K_W1;
            end

            rc4_pkg::ST_K_W1:
            begin
                box_we     = 1'b1;
                box_wd     = box_rd_reg;
                state_next = rc4_pkg::ST_K_W2;
            end

            rc4_pkg::ST_K_W2:
            begin
                box_we   = 1'b1;
                box_wa   = j_reg;
                box_wd   = si_reg;
                i_next   = 8'(i_reg + 8'd1);
                pos_next = (pos_inc >= len_reg) ? '0 : pos_inc[KIDX_W-1:0];
                if (i_reg == rc4_pkg::BOX_LAST)
                begin
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_K_RD;
                end
            end

            rc4_pkg::ST_D_J:
            begin
                si_next    = box_rd_reg;
                box_re     = 1'b1;
                box_ra     = sum_j;
                j_next     = sum_j;
                state_next = rc4_pkg::ST_D_SW;
            end

            rc4_pkg::ST_D_SW:
            begin
                sj_next    = box_rd_reg;
                box_we     = 1'b1;
                box_wd     = box_rd_reg;
                t_next     = 8'(si_reg + box_rd_reg);
                box_re     = 1'b1;
                box_ra     = t_next;
                state_next = rc4_pkg::ST_D_KS;
            end

            rc4_pkg::ST_D_KS:
            begin
                box_we = 1'b1;
                box_wa = j_reg;
                box_wd = si_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_EMIT;
                end
            end

            rc4_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = rc4_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            count_reg     <= '0;
            len_reg       <= '0;
            keyed_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            keyed_reg     <= keyed_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        t_reg      <= t_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_byte_reg   <= res_byte;
            out_status_reg <= status_reg;
            out_last_reg   <= last_reg;
        end
    end

    // state box
    always_ff @(posedge clk)
    begin
        if (box_we)
        begin
            box_mem[box_wa] <= box_wd;
        end
        if (box_re)
        begin
            box_rd_reg <= box_mem[box_ra];
        end
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= s_axis_tdata;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[pos_reg];
        end
    end

    `RC4_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= MAX_CNT)
    `RC4_ASSERT_NEXT(a_sched_end, (state_reg == rc4_pkg::ST_K_W2) && (i_reg == rc4_pkg::BOX_LAST), keyed_reg && (i_reg == 8'd0) && (j_reg == 8'd0) && (state_reg == rc4_pkg::ST_IDLE))
    `RC4_ASSERT_IMP(a_stream_keyed, (state_reg == rc4_pkg::ST_D_J) || (state_reg == rc4_pkg::ST_D_SW) || (state_reg == rc4_pkg::ST_D_KS), keyed_reg && (status_reg == rc4_pkg::STATUS_OK))

endmodule

`default_nettype wire

// ----- bench/rc4_keystream_cipher_tb.sv -----
// self-checking testbench for the rc4 keystream cipher stream engine
`timescale 1ns / 1ps

module rc4_keystream_cipher_tb;

    localparam int KEY_MAX      = 256;
    localparam int ITEM_TARGET  = 1350;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] text;
        logic       status;
        logic       eom;
    } cipher_beat_t;

    typedef struct packed {
        logic         req;
        logic [7:0]   text;
        logic         eom;
        logic         typed;
        cipher_beat_t want;
    } stim_row_t;

    localparam cipher_beat_t NO_WANT = '{8'h00, rc4_pkg::STATUS_OK, 1'b0};

    // unkeyed bytes first, then the classic three-byte key with its nine-byte message,
    // single-byte keys at both extremes and a key loaded while the old one still serves data
    localparam stim_row_t DIRECTED [24] = '{
        '{rc4_pkg::REQ_DATA, 8'h00, 1'b0, 1'b1, '{8'h00, rc4_pkg::STATUS_NOKEY, 1'b0}},
        '{rc4_pkg::REQ_DATA, 8'hff, 1'b1, 1'b1, '{8'hff, rc4_pkg::STATUS_NOKEY, 1'b1}},
        '{rc4_pkg::REQ_DATA, 8'h5a, 1'b0, 1'b1, '{8'h5a, rc4_pkg::STATUS_NOKEY, 1'b0}},
        '{rc4_pkg::REQ_KEY,  8'h4b, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_KEY,  8'h65, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_KEY,  8'h79, 1'b1, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h50, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h6c, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h61, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h69, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h6e, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h74, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h65, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h78, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h74, 1'b1, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_KEY,  8'hff, 1'b1, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'hff, 1'b1, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_KEY,  8'h00, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h80, 1'b0, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_KEY,  8'h01, 1'b1, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'h7f, 1'b1, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_KEY,  8'h00, 1'b1, 1'b0, NO_WANT},
        '{rc4_pkg::REQ_DATA, 8'haa, 1'b1, 1'b0, NO_WANT}
    };

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic [0:0] s_axis_tuser  = rc4_pkg::REQ_KEY;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic       m_axis_tlast;

    // predictor state
    logic [7:0]   pred_box [rc4_pkg::BOX_DEPTH];
    logic [7:0]   pred_key [KEY_MAX];
    int           pred_key_len = 0;
    logic [7:0]   pred_i = 8'h00;
    logic [7:0]   pred_j = 8'h00;
    logic         pred_keyed = 1'b0;

    cipher_beat_t expected_bytes [$];
    cipher_beat_t oldest;
    int           mismatches    = 0;
    int           beats_sent    = 0;
    int           quiet_cycles  = 0;
    int           hold_requests = 0;
    int           holds_taken   = 0;
    int           hold_left     = 0;
    logic         calm          = 1'b0;

    rc4_keystream_cipher #(
        .MAX_KEY_BYTES (KEY_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // advances the cipher state by one accepted beat and gives the byte it produces, if any
    function automatic void keystream_predict(input logic req, input logic [7:0] text,
                                              input logic eom, output logic has_out,
                                              output cipher_beat_t out_beat);
        logic [7:0] sj;
        logic [7:0] tmp;
        logic [7:0] ks;
        int         pos;

        has_out  = 1'b0;
        out_beat = NO_WANT;
        if (req == rc4_pkg::REQ_KEY)
        begin
            // bytes past the store size are dropped, the count saturates
            if (pred_key_len < KEY_MAX)
            begin
                pred_key[pred_key_len] = text;
                pred_key_len++;
            end
            if (eom)
            begin
                for (int k = 0; k < rc4_pkg::BOX_DEPTH; k++)
                    pred_box[k] = 8'(k);
                sj  = 8'h00;
                pos = 0;
                for (int k = 0; k < rc4_pkg::BOX_DEPTH; k++)
                begin
                    sj          = sj + pred_box[k] + pred_key[pos];
                    tmp         = pred_box[k];
                    pred_box[k] = pred_box[sj];
                    pred_box[sj] = tmp;
                    pos++;
                    if (pos >= pred_key_len)
                        pos = 0;
                end
                pred_i       = 8'h00;
                pred_j       = 8'h00;
                pred_keyed   = 1'b1;
                pred_key_len = 0;
            end
        end
        else if (!pred_keyed)
        begin
            has_out  = 1'b1;
            out_beat = '{text, rc4_pkg::STATUS_NOKEY, eom};
        end
        else
        begin
            pred_i           = pred_i + 8'h01;
            pred_j           = pred_j + pred_box[pred_i];
            tmp              = pred_box[pred_i];
            pred_box[pred_i] = pred_box[pred_j];
            pred_box[pred_j] = tmp;
            ks               = pred_box[8'(pred_box[pred_i] + pred_box[pred_j])];
            has_out          = 1'b1;
            out_beat         = '{text ^ ks, rc4_pkg::STATUS_OK, eom};
        end
    endfunction

    // offers one beat after a random gap and records what it should produce once taken
    task automatic send_beat(input logic req, input logic [7:0] text, input logic eom,
                             input logic typed, input cipher_beat_t want);
        logic         has_out;
        cipher_beat_t predicted;

        calm = (beats_sent >= 800 && beats_sent < 1000);
        while (!calm && $urandom_range(99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tuser[0] <= req;
        s_axis_tdata    <= text;
        s_axis_tlast    <= eom;
        do
            @(posedge clk);
        while (!s_axis_tready);
        keystream_predict(req, text, eom, has_out, predicted);
        if (has_out)
            expected_bytes.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // receiver: random back-pressure, plus one long hold when the stimulus asks for it
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (holds_taken != hold_requests)
        begin
            holds_taken   <= holds_taken + 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 17);
    end

    // compare every output beat with the oldest outstanding prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output beat: text %02h status %0d last %0d",
                             m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            end
            else
            begin
                oldest = expected_bytes.pop_front();
                if (m_axis_tdata !== oldest.text || m_axis_tuser[0] !== oldest.status ||
                    m_axis_tlast !== oldest.eom)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: expected text %02h status %0d last %0d, got %02h %0d %0d",
                                 oldest.text, oldest.status, oldest.eom,
                                 m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("rc4_keystream_cipher verification failed");
        $finish;
    end

    initial
    begin
        int   key_len;
        int   msg_len;
        int   msg_count;
        logic long_key_done;

        long_key_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[n])
            send_beat(DIRECTED[n].req, DIRECTED[n].text, DIRECTED[n].eom,
                      DIRECTED[n].typed, DIRECTED[n].want);

        while (beats_sent < ITEM_TARGET)
        begin
            if (!long_key_done || $urandom_range(99) < 82)
            begin
                // first key always overflows the store; later ones are mostly short
                if (!long_key_done)
                    key_len = $urandom_range(300, 257);
                else if ($urandom_range(24) == 0)
                    key_len = $urandom_range(300, 200);
                else
                    key_len = $urandom_range(32, 1);
                long_key_done = 1'b1;
                for (int n = 0; n < key_len; n++)
                begin
                    // data while a new key loads still uses the old box
                    if ($urandom_range(9) == 0)
                        send_beat(rc4_pkg::REQ_DATA, 8'($urandom_range(255)),
                                  1'($urandom_range(1)), 1'b0, NO_WANT);
                    send_beat(rc4_pkg::REQ_KEY, 8'($urandom_range(255)), n == key_len - 1,
                              1'b0, NO_WANT);
                end
                msg_count = $urandom_range(4, 1);
                for (int m = 0; m < msg_count; m++)
                begin
                    msg_len = $urandom_range(40, 1);
                    for (int n = 0; n < msg_len; n++)
                    begin
                        if (hold_requests == 0 && beats_sent >= 500)
                            hold_requests++;
                        send_beat(rc4_pkg::REQ_DATA, 8'($urandom_range(255)),
                                  n == msg_len - 1, 1'b0, NO_WANT);
                    end
                end
            end
            else
            begin
                msg_len = $urandom_range(20, 1);
                for (int n = 0; n < msg_len; n++)
                    send_beat(1'($urandom_range(1)), 8'($urandom_range(255)),
                              $urandom_range(7) == 0, 1'b0, NO_WANT);
            end
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("rc4_keystream_cipher verification clean");
        else
            $display("rc4_keystream_cipher verification failed");
        $finish;
    end

endmodule
